>>> sv/adam_pkg.sv
// Shared types, constants and helper functions for the Adam update core.
// No dependencies; every other file imports this package.
package adam_pkg;

    localparam int NUM_DIMS_DEF = 64;
    localparam int IDX_W        = 6;
    localparam int DATA_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 31;

    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    // iteration counts of the serial unit
    localparam logic [6:0] MUL_ITER  = 7'd32;
    localparam logic [6:0] DIV_ITER  = 7'd64;
    localparam logic [6:0] SQRT_ITER = 7'd24;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_STEP = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOSTEP = 2'd1,
        ST_SAT    = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BETA1 = 3'd0,
        CFG_BETA2 = 3'd1,
        CFG_STEP  = 3'd2,
        CFG_EPS   = 3'd3,
        CFG_AVG   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    go;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        logic [31:0] r;
        r = x[31] ? (~x + 32'd1) : x;
        return r;
    endfunction

    function automatic logic signed [49:0] sgn_term(input logic neg, input logic [47:0] mag);
        logic signed [49:0] t;
        t = $signed({2'b00, mag});
        return neg ? -t : t;
    endfunction

    // {saturated, value}
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        logic [32:0] r;
        if (x > 66'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

endpackage

>>> sv/adam_in_if.sv
// Input channel of the Adam update core: valid/ready plus command payload.
// Depends on adam_pkg.
interface adam_in_if;
    import adam_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;

    modport source(output valid, command, index, value, input ready);
    modport sink(input valid, command, index, value, output ready);
endinterface

>>> sv/adam_out_if.sv
// Result channel of the Adam update core: valid/ready plus result payload.
// Depends on adam_pkg.
interface adam_out_if;
    import adam_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         index_out;
    logic signed [DATA_W-1:0] position_out;
    logic [1:0]               status;

    modport source(output valid, index_out, position_out, status, input ready);
    modport sink(input valid, index_out, position_out, status, output ready);
endinterface

>>> sv/adam_salu.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root. Depends on adam_pkg.
module adam_salu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adam_pkg::t_alu_req  i_req,
    input  logic [63:0]         i_opa,
    input  logic [31:0]         i_opb,
    output logic [63:0]         o_res,
    output logic [31:0]         o_rem,
    output adam_pkg::t_alu_stat o_stat
);
    import adam_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [6:0]  r_cnt;
    logic [63:0] r_a;      // multiplicand / dividend-quotient / radicand
    logic [31:0] r_b;      // multiplier / divisor
    logic [63:0] r_acc;    // product / root
    logic [32:0] r_rem;    // partial remainder

    logic [63:0] n_a;
    logic [31:0] n_b;
    logic [63:0] n_acc;
    logic [32:0] n_rem;
    logic [32:0] div_s;
    logic [26:0] sq_s;
    logic [26:0] sq_t;

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        n_rem = r_rem;
        div_s = {r_rem[31:0], r_a[63]};
        sq_s  = {r_rem[24:0], r_a[47:46]};
        sq_t  = {1'b0, r_acc[23:0], 2'b01};
        case (r_op)
            ALU_MUL: begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[62:0], 1'b0};
                n_b = {1'b0, r_b[31:1]};
            end
            ALU_DIV: begin
                if (div_s >= {1'b0, r_b}) begin
                    n_rem = div_s - {1'b0, r_b};
                    n_a   = {r_a[62:0], 1'b1};
                end else begin
                    n_rem = div_s;
                    n_a   = {r_a[62:0], 1'b0};
                end
            end
            ALU_SQRT: begin
                if (sq_s >= sq_t) begin
                    n_rem = {6'd0, sq_s - sq_t};
                    n_acc = {r_acc[62:0], 1'b1};
                end else begin
                    n_rem = {6'd0, sq_s};
                    n_acc = {r_acc[62:0], 1'b0};
                end
                n_a = {r_a[61:0], 2'b00};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_opa;
                r_b    <= i_opb;
                r_acc  <= '0;
                r_rem  <= '0;
                case (i_req.op)
                    ALU_DIV:  r_cnt <= DIV_ITER;
                    ALU_SQRT: r_cnt <= SQRT_ITER;
                    default:  r_cnt <= MUL_ITER;
                endcase
            end else if (r_busy) begin
                r_a   <= n_a;
                r_b   <= n_b;
                r_acc <= n_acc;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res       = (r_op == ALU_DIV) ? r_a : r_acc;
    assign o_rem       = r_rem[31:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> sv/adam_optimizer_update_core.sv
// Adam update core. One item at a time: load, read and step each run to completion
// before the next item is taken; a step's multiplies, divides and square roots run
// one after another on the serial unit (more of them with averaging and at index 0).
// Synchronous active-low reset restores register defaults; element rows read zero
// until written (row valid bits), so no clearing pass. Depends on adam_pkg, adam_salu.
module adam_optimizer_update_core #(
    parameter int NUM_DIMS = adam_pkg::NUM_DIMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    adam_in_if.sink                          i_in,
    adam_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [adam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adam_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import adam_pkg::*;

    localparam int MEM_DEPTH = (NUM_DIMS < 64) ? NUM_DIMS : 64;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_RD   = 20'h00002,
        S_DEC  = 20'h00004,
        S_B1   = 20'h00008,
        S_B2   = 20'h00010,
        S_S1   = 20'h00020,
        S_F1   = 20'h00040,
        S_F2   = 20'h00080,
        S_M1   = 20'h00100,
        S_M2   = 20'h00200,
        S_G2   = 20'h00400,
        S_V1   = 20'h00800,
        S_V2   = 20'h01000,
        S_SQ   = 20'h02000,
        S_FM   = 20'h04000,
        S_DV   = 20'h08000,
        S_A1   = 20'h10000,
        S_A2   = 20'h20000,
        S_RDV  = 20'h40000,
        S_DONE = 20'h80000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_beta1, r_beta2, r_eps;
    logic [30:0] r_step;
    logic        r_avg_en;

    // global Adam state
    logic [16:0] r_bp1, r_bp2;
    logic [30:0] r_fac;

    // current item
    logic [1:0]  r_cmd;
    logic [5:0]  r_idx;
    logic [31:0] r_val;
    logic [31:0] r_m, r_v, r_p, r_a;
    logic signed [49:0] r_acc;
    logic [63:0] r_prod;
    logic [24:0] r_den;
    logic [31:0] r_res;
    t_status     r_stat;
    logic        r_issued;

    // result register
    logic        r_ovld;
    logic [5:0]  r_oidx;
    logic [31:0] r_opos;
    t_status     r_ostat;

    // element rows {avg, pos, v, m}
    logic [127:0]         r_mem [MEM_DEPTH];
    logic [127:0]         r_mem_q;
    logic [MEM_DEPTH-1:0] r_row_vld;
    logic                 r_vld_q;

    t_alu_req    alu_req;
    t_alu_stat   alu_stat;
    logic [63:0] alu_opa, alu_res;
    logic [31:0] alu_opb, alu_rem;

    logic               in_acc, in_range, done_go, mem_we, is_calc, term_neg;
    logic [ADDR_W-1:0]  mem_addr;
    logic [127:0]       row;
    logic [16:0]        d1, d2, ob1, ob2;
    logic signed [49:0] term, acc_sum;
    logic signed [65:0] q_s, div_sum, rd_q;
    logic [32:0]        pos_sat, rd_sat;
    logic [24:0]        sq_den;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_range = ({7'd0, r_idx} < 13'(NUM_DIMS));
    assign done_go  = (r_state == S_DONE) && (!r_ovld || o_out.ready);
    assign mem_we   = done_go && in_range && (r_cmd == CMD_LOAD || r_cmd == CMD_STEP);
    assign mem_addr = r_idx[ADDR_W-1:0];
    assign row      = r_vld_q ? r_mem_q : '0;

    assign d1  = ONE_Q16 - r_bp1;
    assign d2  = ONE_Q16 - r_bp2;
    assign ob1 = ONE_Q16 - {1'b0, r_beta1};
    assign ob2 = ONE_Q16 - {1'b0, r_beta2};

    assign is_calc = (r_state == S_B1) || (r_state == S_B2) || (r_state == S_S1) ||
                     (r_state == S_F1) || (r_state == S_F2) || (r_state == S_M1) ||
                     (r_state == S_M2) || (r_state == S_G2) || (r_state == S_V1) ||
                     (r_state == S_V2) || (r_state == S_SQ) || (r_state == S_FM) ||
                     (r_state == S_DV) || (r_state == S_A1) || (r_state == S_A2) ||
                     (r_state == S_RDV);

    // sign of the signed product term in the moment/average blends
    always_comb begin
        unique case (r_state)
            S_M1:    term_neg = r_m[31];
            S_M2:    term_neg = r_val[31];
            S_A1:    term_neg = r_a[31];
            S_A2:    term_neg = r_p[31];
            default: term_neg = 1'b0;
        endcase
    end

    assign term    = sgn_term(term_neg, alu_res[47:0]);
    assign acc_sum = r_acc + term;
    assign q_s     = $signed({2'b00, alu_res});
    assign div_sum = $signed({{34{r_p[31]}}, r_p}) + (r_m[31] ? -q_s : q_s);
    assign rd_q    = r_a[31] ? (-q_s - ((alu_rem != 32'd0) ? 66'sd1 : 66'sd0)) : q_s;
    assign pos_sat = sat32(div_sum);
    assign rd_sat  = sat32(rd_q);
    assign sq_den  = ({1'b0, alu_res[23:0]} + {9'd0, r_eps} == 25'd0) ? 25'd1 :
                     ({1'b0, alu_res[23:0]} + {9'd0, r_eps});

    // operand selection for the serial unit
    always_comb begin
        alu_req.go = is_calc && !r_issued;
        alu_req.op = ALU_MUL;
        alu_opa    = '0;
        alu_opb    = '0;
        unique case (r_state)
            S_B1: begin
                alu_opa = {47'd0, r_bp1};
                alu_opb = {16'd0, r_beta1};
            end
            S_B2: begin
                alu_opa = {47'd0, r_bp2};
                alu_opb = {16'd0, r_beta2};
            end
            S_S1: begin
                alu_req.op = ALU_SQRT;
                alu_opa    = {31'd0, d2, 16'd0};
            end
            S_F1: begin
                alu_opa = {33'd0, r_step};
                alu_opb = {7'd0, r_den};
            end
            S_F2: begin
                alu_req.op = ALU_DIV;
                alu_opa    = r_prod;
                alu_opb    = {15'd0, d1};
            end
            S_M1: begin
                alu_opa = {32'd0, abs32(r_m)};
                alu_opb = {16'd0, r_beta1};
            end
            S_M2: begin
                alu_opa = {32'd0, abs32(r_val)};
                alu_opb = {15'd0, ob1};
            end
            S_G2: begin
                alu_opa = {32'd0, abs32(r_val)};
                alu_opb = abs32(r_val);
            end
            S_V1: begin
                alu_opa = {32'd0, r_v};
                alu_opb = {16'd0, r_beta2};
            end
            S_V2: begin
                alu_opa = {32'd0, r_val};
                alu_opb = {15'd0, ob2};
            end
            S_SQ: begin
                alu_req.op = ALU_SQRT;
                alu_opa    = {16'd0, r_v, 16'd0};
            end
            S_FM: begin
                alu_opa = {33'd0, r_fac};
                alu_opb = abs32(r_m);
            end
            S_DV: begin
                alu_req.op = ALU_DIV;
                alu_opa    = r_prod;
                alu_opb    = {7'd0, r_den};
            end
            S_A1: begin
                alu_opa = {32'd0, abs32(r_a)};
                alu_opb = {16'd0, r_beta2};
            end
            S_A2: begin
                alu_opa = {32'd0, abs32(r_p)};
                alu_opb = {15'd0, ob2};
            end
            S_RDV: begin
                alu_req.op = ALU_DIV;
                alu_opa    = {16'd0, abs32(r_a), 16'd0};
                alu_opb    = {15'd0, d2};
            end
            default: ;
        endcase
    end

    adam_salu u_salu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_opa   (alu_opa),
        .i_opb   (alu_opb),
        .o_res   (alu_res),
        .o_rem   (alu_rem),
        .o_stat  (alu_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_RD;
            S_RD:   n_state = S_DEC;
            S_DEC: begin
                if (!in_range) begin
                    n_state = S_DONE;
                end else begin
                    unique case (r_cmd)
                        CMD_STEP: n_state = (r_idx == 6'd0) ? S_B1 : S_M1;
                        CMD_READ: n_state = (d2 == 17'd0) ? S_DONE : S_RDV;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_B1:  if (alu_stat.done) n_state = S_B2;
            S_B2:  if (alu_stat.done) n_state = S_S1;
            S_S1:  if (alu_stat.done) n_state = S_F1;
            S_F1:  if (alu_stat.done) n_state = (d1 == 17'd0) ? S_M1 : S_F2;
            S_F2:  if (alu_stat.done) n_state = S_M1;
            S_M1:  if (alu_stat.done) n_state = S_M2;
            S_M2:  if (alu_stat.done) n_state = S_G2;
            S_G2:  if (alu_stat.done) n_state = S_V1;
            S_V1:  if (alu_stat.done) n_state = S_V2;
            S_V2:  if (alu_stat.done) n_state = S_SQ;
            S_SQ:  if (alu_stat.done) n_state = S_FM;
            S_FM:  if (alu_stat.done) n_state = S_DV;
            S_DV:  if (alu_stat.done) n_state = r_avg_en ? S_A1 : S_DONE;
            S_A1:  if (alu_stat.done) n_state = S_A2;
            S_A2:  if (alu_stat.done) n_state = S_DONE;
            S_RDV: if (alu_stat.done) n_state = S_DONE;
            S_DONE: if (done_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and global state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_beta1  <= 16'd58982;
            r_beta2  <= 16'd65470;
            r_step   <= 31'd66;
            r_eps    <= 16'd1;
            r_avg_en <= 1'b0;
            r_bp1    <= ONE_Q16;
            r_bp2    <= ONE_Q16;
            r_fac    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (alu_req.go) begin
                r_issued <= 1'b1;
            end else if (alu_stat.done) begin
                r_issued <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BETA1: r_beta1  <= i_cfg_data[15:0];
                    CFG_BETA2: r_beta2  <= i_cfg_data[15:0];
                    CFG_STEP:  r_step   <= i_cfg_data;
                    CFG_EPS:   r_eps    <= i_cfg_data[15:0];
                    CFG_AVG:   r_avg_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (alu_stat.done) begin
                if (r_state == S_B1) r_bp1 <= alu_res[32:16];
                if (r_state == S_B2) r_bp2 <= alu_res[32:16];
                if (r_state == S_F1 && d1 == 17'd0) r_fac <= '0;
                if (r_state == S_F2) r_fac <= (|alu_res[63:31]) ? '1 : alu_res[30:0];
            end
            if (done_go) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in.command;
            r_idx <= i_in.index;
            r_val <= i_in.value;
        end
        if (r_state == S_DEC) begin
            r_m    <= row[31:0];
            r_v    <= row[63:32];
            r_a    <= row[127:96];
            if (in_range && r_cmd == CMD_LOAD) begin
                r_p   <= r_val;
                r_res <= r_val;
            end else begin
                r_p   <= row[95:64];
                r_res <= '0;
            end
            if (in_range && r_cmd == CMD_READ && d2 == 17'd0) begin
                r_stat <= ST_NOSTEP;
            end else begin
                r_stat <= ST_OK;
            end
        end
        if (alu_stat.done) begin
            unique case (r_state)
                S_S1:  r_den  <= alu_res[24:0];
                S_F1:  r_prod <= alu_res;
                S_M1:  r_acc  <= term;
                S_M2:  r_m    <= acc_sum[47:16];
                S_G2:  r_val  <= (|alu_res[63:48]) ? '1 : alu_res[47:16];
                S_V1:  r_acc  <= term;
                S_V2:  r_v    <= acc_sum[47:16];
                S_SQ:  r_den  <= sq_den;
                S_FM:  r_prod <= alu_res;
                S_DV: begin
                    r_p    <= pos_sat[31:0];
                    r_res  <= pos_sat[31:0];
                    r_stat <= pos_sat[32] ? ST_SAT : ST_OK;
                end
                S_A1:  r_acc  <= term;
                S_A2:  r_a    <= acc_sum[47:16];
                S_RDV: begin
                    r_res  <= rd_sat[31:0];
                    r_stat <= rd_sat[32] ? ST_SAT : ST_OK;
                end
                default: ;
            endcase
        end
        if (done_go) begin
            r_oidx  <= r_idx;
            r_opos  <= r_res;
            r_ostat <= r_stat;
        end
    end

    // element row store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= {r_a, r_p, r_v, r_m};
        end
        if (r_state == S_RD) begin
            r_mem_q <= r_mem[mem_addr];
            r_vld_q <= r_row_vld[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (mem_we) begin
            r_row_vld[mem_addr] <= 1'b1;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovld;
    assign o_out.index_out    = r_oidx;
    assign o_out.position_out = r_opos;
    assign o_out.status       = r_ostat;

    a_alu_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.go |-> !alu_stat.busy)
        else $error("serial unit started while busy");

    a_acc_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RD))
        else $error("accepted transfer did not start a row read");

    a_we_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_DONE && in_range))
        else $error("row write outside completion or range");

    a_pow_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp1 <= ONE_Q16) && (r_bp2 <= ONE_Q16))
        else $error("beta power above one");

    a_ovld_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule

>>> bench/adam_update_checker.sv
// Checker for the Adam update core: predicts every result from the accepted items
// and the register writes, and compares the results as they leave. Depends on adam_pkg.
`timescale 1ns / 100ps
module adam_update_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    adam_in_if                               in_ch,
    adam_out_if                              out_ch,
    input  logic                             i_cfg_we,
    input  logic [adam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adam_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);
    import adam_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [31:0]      pos;
        logic [1:0]       status;
    } t_element_result;

    t_element_result expected_results[$];

    logic [15:0] beta1, beta2, epsilon;
    logic [30:0] step_size;
    logic        use_avg;

    int          first_mom[64];
    int unsigned second_mom[64];
    int          pos_vec[64];
    int          avg_vec[64];
    longint      b1_pow, b2_pow, factor;

    function automatic longint root64(input longint x_in);
        logic [63:0] x, r, bit_v;
        x = x_in;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= r + bit_v) begin
                x = x - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint clamp32(input longint x, inout logic sat);
        if (x > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    task automatic predict_element(input logic [1:0] cmd, input logic [5:0] idx,
                                   input logic signed [31:0] val);
        t_element_result r;
        longint g, m, g2, v, den, delta, d1, d2, s, f, a, q, np;
        logic sat;
        sat = 1'b0;
        r.idx = idx;
        r.pos = 32'd0;
        r.status = ST_OK;
        g = longint'(val);
        if (cmd == CMD_LOAD) begin
            pos_vec[idx] = val;
            r.pos = val;
        end else if (cmd == CMD_STEP) begin
            if (idx == 0) begin
                b1_pow = (b1_pow * longint'(beta1)) >> 16;
                b2_pow = (b2_pow * longint'(beta2)) >> 16;
                d1 = 65536 - b1_pow;
                d2 = 65536 - b2_pow;
                s = root64(d2 << 16);
                f = (d1 == 0) ? 0 : (longint'(step_size) * s) / d1;
                factor = (f > 64'sd2147483647) ? 64'sd2147483647 : f;
            end
            m = (longint'(beta1) * longint'(first_mom[idx])
                 + longint'(65536 - longint'(beta1)) * g) >>> 16;
            first_mom[idx] = int'(m);
            g2 = (g < 0) ? -g : g;
            g2 = (g2 * g2) >> 16;
            if (g2 > 64'sd4294967295) g2 = 64'sd4294967295;
            v = (longint'(beta2) * longint'(second_mom[idx])
                 + (65536 - longint'(beta2)) * g2) >> 16;
            second_mom[idx] = int'(v);
            den = root64(v << 16) + longint'(epsilon);
            if (den == 0) den = 1;
            delta = (factor * m) / den;
            np = clamp32(longint'(pos_vec[idx]) + delta, sat);
            pos_vec[idx] = int'(np);
            if (use_avg) begin
                avg_vec[idx] = int'((longint'(beta2) * longint'(avg_vec[idx])
                    + (65536 - longint'(beta2)) * longint'(pos_vec[idx])) >>> 16);
            end
            r.pos = pos_vec[idx];
            r.status = sat ? ST_SAT : ST_OK;
        end else if (cmd == CMD_READ) begin
            d2 = 65536 - b2_pow;
            if (d2 == 0) begin
                r.status = ST_NOSTEP;
            end else begin
                a = longint'(avg_vec[idx]) * 65536;
                q = a / d2;
                if (a < 0 && q * d2 != a) q = q - 1;
                r.pos = clamp32(q, sat);
                r.status = sat ? ST_SAT : ST_OK;
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_element_result e;
        if (!i_rst_n) begin
            beta1 = 16'd58982; beta2 = 16'd65470; step_size = 31'd66;
            epsilon = 16'd1; use_avg = 1'b0;
            for (int i = 0; i < 64; i++) begin
                first_mom[i] = 0; second_mom[i] = 0; pos_vec[i] = 0; avg_vec[i] = 0;
            end
            b1_pow = 65536; b2_pow = 65536; factor = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BETA1: beta1 = i_cfg_data[15:0];
                    CFG_BETA2: beta2 = i_cfg_data[15:0];
                    CFG_STEP:  step_size = i_cfg_data;
                    CFG_EPS:   epsilon = i_cfg_data[15:0];
                    CFG_AVG:   use_avg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result idx=%0d pos=%h status=%0d", $time,
                             out_ch.index_out, out_ch.position_out, out_ch.status);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.index_out !== e.idx) begin
                        $display("%0t: index_out expected %0d actual %0d", $time,
                                 e.idx, out_ch.index_out);
                        o_errors++;
                    end
                    if (out_ch.position_out !== e.pos) begin
                        $display("%0t: position_out expected %h actual %h", $time,
                                 e.pos, out_ch.position_out);
                        o_errors++;
                    end
                    if (out_ch.status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.status, out_ch.status);
                        o_errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_element(in_ch.command, in_ch.index, in_ch.value);
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule

>>> bench/testbench.sv
// Top of the Adam update core bench: clock, reset, register writes, stimulus,
// result-side stalls and verdict. Depends on adam_pkg, the channel interfaces, the checker.
`timescale 1ns / 100ps
module testbench;
    import adam_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int   errors, pending, idle_cycles;
    logic quiet, hold_long;

    adam_in_if  in_ch();
    adam_out_if out_ch();

    adam_optimizer_update_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    adam_update_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[adam_optimizer_update_core] ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int k;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            k = quiet ? 0 : $urandom_range(0, 19);
            repeat (k) begin
                out_ch.ready <= 1'b0;
                @(negedge i_clk);
            end
            if (hold_long) begin
                out_ch.ready <= 1'b0;
                repeat (600) @(negedge i_clk);
                hold_long = 1'b0;
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_element(input logic [1:0] cmd, input logic [5:0] idx,
                                input logic [31:0] val);
        int k;
        k = quiet ? 0 : $urandom_range(0, 19);
        repeat (k) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.index   <= idx;
        in_ch.value   <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] b1, input logic [15:0] b2,
                            input logic [30:0] st, input logic [15:0] ep, input logic av);
        write_reg(CFG_BETA1, {15'd0, b1});
        write_reg(CFG_BETA2, {15'd0, b2});
        write_reg(CFG_STEP, st);
        write_reg(CFG_EPS, {15'd0, ep});
        write_reg(CFG_AVG, {30'd0, av});
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 131071) - 65536;
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // step sweeps from element 0, mostly short, some full, with random commands mixed in
    task automatic random_phase(input int n);
        int count, span, j;
        count = 0;
        while (count < n) begin
            span = $urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 8);
            if ($urandom_range(0, 4) != 0) begin
                send_element(CMD_STEP, 6'd0, rand_value());
                count++;
                for (j = 1; j < span && count < n; j++) begin
                    send_element(CMD_STEP, 6'(j), rand_value());
                    count++;
                end
            end
            repeat ($urandom_range(1, 4)) begin
                send_element(2'($urandom_range(0, 3)), 6'($urandom), rand_value());
                count++;
            end
        end
    endtask

    initial begin
        quiet = 1'b0;
        hold_long = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.index = '0;
        in_ch.value = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: read before any step, steps ahead of element 0, extremes
        send_element(CMD_READ, 6'd3, 32'h0);
        send_element(CMD_LOAD, 6'd5, 32'h7FFF_FFFF);
        send_element(CMD_LOAD, 6'd63, 32'h8000_0000);
        send_element(CMD_STEP, 6'd5, 32'h0001_0000);
        send_element(2'd3, 6'd7, 32'hFFFF_FFFF);
        send_element(CMD_READ, 6'd63, 32'hFFFF_FFFF);
        send_element(CMD_STEP, 6'd0, 32'h8000_0000);
        send_element(CMD_STEP, 6'd63, 32'h8000_0000);
        send_element(CMD_STEP, 6'd5, 32'h7FFF_FFFF);
        send_element(CMD_STEP, 6'd9, 32'h0);
        send_element(CMD_READ, 6'd0, 32'h0);
        // large rate, averaging on, zero guard: saturation and zero denominator
        set_regs(16'd0, 16'd65535, 31'h7FFF_FFFF, 16'd0, 1'b1);
        send_element(CMD_STEP, 6'd0, 32'h0);
        send_element(CMD_STEP, 6'd5, 32'h7FFF_FFFF);
        send_element(CMD_STEP, 6'd63, 32'h8000_0000);
        send_element(CMD_STEP, 6'd20, 32'h0);
        send_element(CMD_READ, 6'd5, 32'h0);
        send_element(CMD_READ, 6'd63, 32'h0);

        // receiver holds off while items keep coming
        hold_long = 1'b1;
        quiet = 1'b1;
        random_phase(20);
        quiet = 1'b0;
        random_phase(130);

        set_regs(16'd65535, 16'd0, 31'd0, 16'd65535, 1'b0);
        random_phase(120);

        set_regs(16'd58982, 16'd65470, 31'd66, 16'd1, 1'b1);
        quiet = 1'b1;
        random_phase(60);
        quiet = 1'b0;
        random_phase(80);

        set_regs(16'($urandom), 16'($urandom_range(60000, 65535)),
                 31'($urandom_range(1, 1 << 20)), 16'($urandom_range(1, 65535)), 1'b1);
        random_phase(120);

        set_regs(16'($urandom), 16'($urandom), 31'($urandom), 16'($urandom), 1'b0);
        random_phase(100);

        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (600) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("[adam_optimizer_update_core] OK");
        else
            $display("[adam_optimizer_update_core] ERROR");
        $finish;
    end
endmodule
